// ===== hw/rtl/dlfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfr_pkg
// Shared types, constants and the CRC-16/DNP byte update for the link
// frame receiver.
// ----------------------------------------------------------------------------
package dlfr_pkg;

  localparam int unsigned DefCountWidth = 32;
  localparam logic [7:0]  StartFirst    = 8'h05;
  localparam logic [7:0]  StartSecond   = 8'h64;
  localparam logic [15:0] CrcPolyRefl   = 16'hA6BC;
  localparam int unsigned BlockBytes    = 16;
  localparam int unsigned QueueDepth    = 4;

  typedef enum logic [1:0] {
    EV_PAYLOAD  = 2'd0,
    EV_HDR_ONLY = 2'd1,
    EV_HDR_REJ  = 2'd2,
    EV_BLK_ERR  = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_HEADER = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  // header fields as held by the front and carried with each command
  typedef struct packed {
    logic [7:0]  length_field;
    logic [7:0]  control_byte;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
  } hdr_t;

  // one command from front to back: a single event, or a block release
  typedef struct packed {
    logic       is_block;   // release bytes 0..cnt-1 of buffer slot buf_sel
    event_t     ev;         // event for non-block commands
    logic [4:0] cnt;        // number of bytes in block (1..16)
    logic       done;       // frame ends with this block
    logic [1:0] buf_sel;    // block buffer slot
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPolyRefl) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dnp3_link_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// dnp3_link_frame_receiver
// Link frame receiver: start-pair hunt, header and per-block CRC-16 checks,
// release of checked block bytes as result transactions.
// ----------------------------------------------------------------------------
// with the result stage idle, the command of an accepted byte is written into
// the command queue and then loaded into the output register as a result
// throughput: one byte a cycle in unless stalled; a block releases one
// result a cycle while popped; the front stalls when the 4-entry command
// queue is full, or at a block start while all 4 block slots wait to drain
// reset: synchronous rst_n clears phase, counters, queue and output stage
module dnp3_link_frame_receiver #(
  parameter int unsigned COUNT_WIDTH = dlfr_pkg::DefCountWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             in_rx_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             out_event_res,
  output logic [7:0]             out_payload_byte,
  output logic                   out_frame_end,
  output logic                   out_last_of_run,
  output logic [7:0]             out_control_byte,
  output logic [15:0]            out_dest_addr,
  output logic [15:0]            out_src_addr,
  output logic [7:0]             out_length_field,
  output logic [COUNT_WIDTH-1:0] out_lost_count,
  output logic [COUNT_WIDTH-1:0] out_start_count,
  output logic [COUNT_WIDTH-1:0] out_crc_error_count
);
  import dlfr_pkg::*;

  logic                   cmd_push, cmd_full, slot_free, slot_take, buf_we;
  cmd_t                   cmd_data;
  hdr_t                   cmd_hdr, o_hdr;
  logic [COUNT_WIDTH-1:0] c_lost, c_start, c_crcerr;
  logic [1:0]             slot_wr;
  logic [5:0]             buf_waddr;
  logic [7:0]             buf_wdata;

  dlfr_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(push), .in_byte(in_rx_byte), .in_stall(full),
    .cmd_push(cmd_push), .cmd_data(cmd_data), .cmd_hdr(cmd_hdr), .cmd_lost(c_lost),
    .cmd_start(c_start), .cmd_crcerr(c_crcerr), .cmd_full(cmd_full),
    .slot_free(slot_free), .slot_wr(slot_wr), .slot_take(slot_take),
    .buf_we(buf_we), .buf_waddr(buf_waddr), .buf_wdata(buf_wdata)
  );

  dlfr_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_push(cmd_push), .cmd_data(cmd_data),
    .cmd_hdr(cmd_hdr), .cmd_lost(c_lost), .cmd_start(c_start), .cmd_crcerr(c_crcerr),
    .cmd_full(cmd_full), .slot_free(slot_free), .slot_wr(slot_wr), .slot_take(slot_take),
    .buf_we(buf_we), .buf_waddr(buf_waddr), .buf_wdata(buf_wdata),
    .out_empty(empty), .out_pop(pop), .out_ev(out_event_res), .out_pay(out_payload_byte),
    .out_fend(out_frame_end), .out_last(out_last_of_run), .out_hdr(o_hdr),
    .out_lost(out_lost_count), .out_start(out_start_count),
    .out_crcerr(out_crc_error_count)
  );

  assign out_control_byte = o_hdr.control_byte;
  assign out_dest_addr    = o_hdr.dest_addr;
  assign out_src_addr     = o_hdr.src_addr;
  assign out_length_field = o_hdr.length_field;

  // a frame end is always the last result of its block run
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> out_last_of_run) else $error("frame end not last");

  // frame end only marks payload bytes
  a_fend_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_frame_end) |-> (out_event_res == EV_PAYLOAD))
    else $error("frame end on non-payload");

  // the lost count never moves backwards between consecutive results
  a_lost_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop) |=> (empty || out_lost_count >= $past(out_lost_count)))
    else $error("lost count went backwards");

endmodule

// ===== hw/rtl/dlfr_ram.sv =====
// ----------------------------------------------------------------------------
// dlfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dlfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/dlfr_front.sv =====
// ----------------------------------------------------------------------------
// dlfr_front
// Hunts for the start pair, checks header and block CRCs, writes block bytes
// into the shared byte buffer and issues commands to the back end.
// ----------------------------------------------------------------------------
module dlfr_front #(
  parameter int unsigned COUNT_WIDTH = dlfr_pkg::DefCountWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  output logic                   in_stall,
  // command queue write side
  output logic                   cmd_push,
  output dlfr_pkg::cmd_t         cmd_data,
  output dlfr_pkg::hdr_t         cmd_hdr,
  output logic [COUNT_WIDTH-1:0] cmd_lost,
  output logic [COUNT_WIDTH-1:0] cmd_start,
  output logic [COUNT_WIDTH-1:0] cmd_crcerr,
  input  logic                   cmd_full,
  input  logic                   slot_free,   // a buffer slot is free for a new block
  input  logic [1:0]             slot_wr,     // slot being filled
  output logic                   slot_take,   // block committed, advance slot
  // byte buffer write
  output logic                   buf_we,
  output logic [5:0]             buf_waddr,
  output logic [7:0]             buf_wdata
);
  import dlfr_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  phase_t           phase_r, phase_nxt;
  logic [3:0]       hpos_r, hpos_nxt;       // header byte index 2..9
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       hdr_crc_lo_r, hdr_crc_lo_nxt;
  hdr_t             hdr_r, hdr_nxt;
  logic [7:0]       ud_left_r, ud_left_nxt; // user bytes remaining in frame
  logic [4:0]       bidx_r, bidx_nxt;       // position within block incl crc
  logic [COUNT_WIDTH-1:0] lost_r, lost_nxt, start_r, start_nxt, crcerr_r, crcerr_nxt;

  logic       fire;
  logic [4:0] dlen;
  logic [15:0] hdr_rx;
  logic        hdr_ok_len, hdr_ok_crc;

  // stall when the next byte could need a queue entry or a buffer slot
  always_comb begin
    in_stall = cmd_full;
    if (phase_r == PH_DATA && bidx_r == 5'd0 && !slot_free) begin
      in_stall = 1'b1;
    end
  end

  assign fire = in_valid && !in_stall;
  assign dlen = (ud_left_r >= 8'd16) ? 5'd16 : ud_left_r[4:0];
  assign hdr_rx = {in_byte, hdr_crc_lo_r};
  assign hdr_ok_len = (hdr_r.length_field >= 8'd5);
  assign hdr_ok_crc = (~crc_r == hdr_rx);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  always_comb begin
    phase_nxt      = phase_r;
    hpos_nxt       = hpos_r;
    crc_nxt        = crc_r;
    crc_lo_nxt     = crc_lo_r;
    hdr_crc_lo_nxt = hdr_crc_lo_r;
    hdr_nxt        = hdr_r;
    ud_left_nxt    = ud_left_r;
    bidx_nxt       = bidx_r;
    lost_nxt       = lost_r;
    start_nxt      = start_r;
    crcerr_nxt     = crcerr_r;
    cmd_push       = 1'b0;
    cmd_data       = '0;
    slot_take      = 1'b0;
    buf_we         = 1'b0;
    buf_waddr      = {slot_wr, bidx_r[3:0]};
    buf_wdata      = in_byte;
    if (fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_byte == StartFirst) phase_nxt = PH_SECOND;
          else lost_nxt = sat_inc(lost_r);
        end
        PH_SECOND: begin
          if (in_byte == StartSecond) begin
            start_nxt = sat_inc(start_r);
            phase_nxt = PH_HEADER;
            hpos_nxt  = 4'd2;
            crc_nxt   = crc_byte(crc_byte(16'h0000, StartFirst), StartSecond);
          end else begin
            // the broken pair costs one lost byte, then this byte is rehunted
            if (in_byte == StartFirst) begin
              lost_nxt  = sat_inc(lost_r);
              phase_nxt = PH_SECOND;
            end else begin
              lost_nxt  = sat_inc(sat_inc(lost_r));
              phase_nxt = PH_HUNT;
            end
          end
        end
        PH_HEADER: begin
          case (hpos_r)
            4'd2: hdr_nxt.length_field = in_byte;
            4'd3: hdr_nxt.control_byte = in_byte;
            4'd4: hdr_nxt.dest_addr[7:0] = in_byte;
            4'd5: hdr_nxt.dest_addr[15:8] = in_byte;
            4'd6: hdr_nxt.src_addr[7:0] = in_byte;
            4'd7: hdr_nxt.src_addr[15:8] = in_byte;
            4'd8: hdr_crc_lo_nxt = in_byte;
            default: ;
          endcase
          if (hpos_r < 4'd8) begin
            crc_nxt  = crc_byte(crc_r, in_byte);
            hpos_nxt = hpos_r + 4'd1;
          end else if (hpos_r == 4'd8) begin
            hpos_nxt = 4'd9;
          end else begin
            if (!hdr_ok_crc) crcerr_nxt = sat_inc(crcerr_r);
            if (!hdr_ok_len || !hdr_ok_crc) begin
              cmd_push     = 1'b1;
              cmd_data.ev  = EV_HDR_REJ;
              phase_nxt    = PH_HUNT;
            end else if (hdr_r.length_field == 8'd5) begin
              cmd_push     = 1'b1;
              cmd_data.ev  = EV_HDR_ONLY;
              phase_nxt    = PH_HUNT;
            end else begin
              phase_nxt   = PH_DATA;
              ud_left_nxt = hdr_r.length_field - 8'd5;
              bidx_nxt    = 5'd0;
              crc_nxt     = 16'h0000;
            end
          end
        end
        PH_DATA: begin
          if (bidx_r < dlen) begin
            buf_we   = 1'b1;
            crc_nxt  = crc_byte(crc_r, in_byte);
            bidx_nxt = bidx_r + 5'd1;
          end else if (bidx_r == dlen) begin
            crc_lo_nxt = in_byte;
            bidx_nxt   = bidx_r + 5'd1;
          end else begin
            cmd_push = 1'b1;
            bidx_nxt = 5'd0;
            crc_nxt  = 16'h0000;
            if (~crc_r != {in_byte, crc_lo_r}) begin
              crcerr_nxt  = sat_inc(crcerr_r);
              cmd_data.ev = EV_BLK_ERR;
              phase_nxt   = PH_HUNT;
            end else begin
              cmd_data.is_block = 1'b1;
              cmd_data.ev       = EV_PAYLOAD;
              cmd_data.cnt      = dlen;
              cmd_data.done     = (ud_left_r == {3'b000, dlen});
              cmd_data.buf_sel  = slot_wr;
              slot_take         = 1'b1;
              ud_left_nxt       = ud_left_r - {3'b000, dlen};
              if (ud_left_r == {3'b000, dlen}) phase_nxt = PH_HUNT;
            end
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  assign cmd_hdr    = hdr_nxt;
  assign cmd_lost   = lost_nxt;
  assign cmd_start  = start_nxt;
  assign cmd_crcerr = crcerr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hpos_r    <= 4'd0;
      crc_r     <= 16'h0000;
      crc_lo_r  <= 8'h00;
      ud_left_r <= 8'h00;
      bidx_r    <= 5'd0;
      lost_r    <= '0;
      start_r   <= '0;
      crcerr_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hpos_r    <= hpos_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
      ud_left_r <= ud_left_nxt;
      bidx_r    <= bidx_nxt;
      lost_r    <= lost_nxt;
      start_r   <= start_nxt;
      crcerr_r  <= crcerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r        <= hdr_nxt;
    hdr_crc_lo_r <= hdr_crc_lo_nxt;
  end

endmodule

// ===== hw/rtl/dlfr_back.sv =====
// ----------------------------------------------------------------------------
// dlfr_back
// Command queue and result stage: expands each command into result
// transactions, reading block bytes one per cycle from the buffer unless held.
// ----------------------------------------------------------------------------
module dlfr_back #(
  parameter int unsigned COUNT_WIDTH = dlfr_pkg::DefCountWidth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_push,
  input  dlfr_pkg::cmd_t         cmd_data,
  input  dlfr_pkg::hdr_t         cmd_hdr,
  input  logic [COUNT_WIDTH-1:0] cmd_lost,
  input  logic [COUNT_WIDTH-1:0] cmd_start,
  input  logic [COUNT_WIDTH-1:0] cmd_crcerr,
  output logic                   cmd_full,
  output logic                   slot_free,
  output logic [1:0]             slot_wr,
  input  logic                   slot_take,
  input  logic                   buf_we,
  input  logic [5:0]             buf_waddr,
  input  logic [7:0]             buf_wdata,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [1:0]             out_ev,
  output logic [7:0]             out_pay,
  output logic                   out_fend,
  output logic                   out_last,
  output dlfr_pkg::hdr_t         out_hdr,
  output logic [COUNT_WIDTH-1:0] out_lost,
  output logic [COUNT_WIDTH-1:0] out_start,
  output logic [COUNT_WIDTH-1:0] out_crcerr
);
  import dlfr_pkg::*;

  localparam int unsigned QW = $clog2(QueueDepth);

  typedef struct packed {
    cmd_t                   cmd;
    hdr_t                   hdr;
    logic [COUNT_WIDTH-1:0] lost;
    logic [COUNT_WIDTH-1:0] start;
    logic [COUNT_WIDTH-1:0] crcerr;
  } entry_t;

  entry_t            q_r [QueueDepth];
  logic [QW-1:0]     qwp_r, qrp_r;
  logic [QW:0]       qcnt_r;
  logic [1:0]        slot_wr_r;
  logic [2:0]        slots_used_r;

  // output register
  logic              ov_r;
  logic [1:0]        oev_r;
  logic              ofend_r, olast_r;
  logic              obyte_r;    // payload comes from ram read data
  entry_t            oent_r;

  logic [4:0]        rptr_r;     // byte index within current block
  entry_t            head;
  logic              q_pop, take_out, load;
  logic [7:0]        rd_data;
  logic              blk_last;

  assign head      = q_r[qrp_r];
  assign cmd_full  = (qcnt_r == (QW+1)'(QueueDepth));
  assign slot_free = (slots_used_r < 3'd4);
  assign slot_wr   = slot_wr_r;

  assign take_out  = ov_r && out_pop;
  assign load      = (qcnt_r != '0) && (!ov_r || out_pop);
  assign blk_last  = head.cmd.is_block ? (rptr_r + 5'd1 == head.cmd.cnt) : 1'b1;
  assign q_pop     = load && blk_last;

  dlfr_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_waddr),
    .wr_data (buf_wdata),
    .rd_en   (load),
    .rd_addr ({head.cmd.buf_sel, rptr_r[3:0]}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd_push) begin
      q_r[qwp_r] <= '{cmd: cmd_data, hdr: cmd_hdr, lost: cmd_lost, start: cmd_start,
                      crcerr: cmd_crcerr};
    end
    if (load) begin
      oent_r  <= head;
      oev_r   <= head.cmd.ev;
      obyte_r <= head.cmd.is_block;
      ofend_r <= head.cmd.is_block && head.cmd.done && blk_last;
      olast_r <= blk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qwp_r        <= '0;
      qrp_r        <= '0;
      qcnt_r       <= '0;
      rptr_r       <= 5'd0;
      ov_r         <= 1'b0;
      slot_wr_r    <= 2'd0;
      slots_used_r <= 3'd0;
    end else begin
      if (cmd_push) qwp_r <= qwp_r + 1'b1;
      if (q_pop)    qrp_r <= qrp_r + 1'b1;
      qcnt_r <= qcnt_r + (QW+1)'(cmd_push) - (QW+1)'(q_pop);
      if (load) rptr_r <= blk_last ? 5'd0 : rptr_r + 5'd1;
      if (load) ov_r <= 1'b1;
      else if (take_out) ov_r <= 1'b0;
      // slots are freed in order as block commands retire
      if (slot_take) slot_wr_r <= slot_wr_r + 2'd1;
      slots_used_r <= slots_used_r + {2'b00, slot_take}
                      - {2'b00, q_pop && head.cmd.is_block};
    end
  end

  assign out_empty  = !ov_r;
  assign out_ev     = oev_r;
  assign out_pay    = obyte_r ? rd_data : 8'h00;
  assign out_fend   = ofend_r;
  assign out_last   = olast_r;
  assign out_hdr    = oent_r.hdr;
  assign out_lost   = oent_r.lost;
  assign out_start  = oent_r.start;
  assign out_crcerr = oent_r.crcerr;

endmodule
